>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the encoder modules.
// QPE_ASSERT_SAME: the consequent must hold in the same cycle as the antecedent.
// QPE_ASSERT_NEXT: the consequent must hold one cycle after the antecedent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define QPE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qpe assertion failed");

`define QPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qpe assertion failed");

`else

`define QPE_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define QPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/qpe_pkg.sv
`default_nettype none

package qpe_pkg;

    localparam logic [7:0] CHAR_EQ     = 8'h3D;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [6:0] COL_MAX     = 7'd127;
    localparam logic [6:0] BREAK_RESET = 7'd73;

    // One classified byte on its way from the front end to the emitter.
    typedef struct packed {
        logic [7:0] data;
        logic       literal;
        logic       brk;
    } job_t;

    // Literal set: space, ' ( ) + , - . / digits : ? and letters.
    function automatic logic is_literal(input logic [7:0] b);
        logic lit;
        lit = (b == 8'd32) || (b == 8'd58) || (b == 8'd63)
            || ((b >= 8'd39) && (b <= 8'd41))
            || ((b >= 8'd43) && (b <= 8'd57))
            || ((b >= 8'd65) && (b <= 8'd90))
            || ((b >= 8'd97) && (b <= 8'd122));
        return lit;
    endfunction

    // Upper-case hex digit for a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] ch;
        if (n < 4'd10)
        begin
            ch = 8'h30 + {4'b0000, n};
        end
        else
        begin
            ch = 8'h37 + {4'b0000, n};
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/qpe_front.sv
`default_nettype none

module qpe_front
    import qpe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic [6:0] break_column,
    input  wire logic       push,
    input  wire logic [7:0] in_byte,
    input  wire logic       message_end,
    input  wire logic       q_full,
    output logic            q_write,
    output job_t            q_data
);

    logic [6:0] break_column_reg;
    logic [6:0] line_column_reg;
    logic [6:0] line_column_next;
    logic       lit;
    logic [1:0] n_chars;
    logic [7:0] sum;
    logic [6:0] col;
    logic       brk;

    assign q_write = push && !q_full;
    assign lit     = is_literal(in_byte);
    assign n_chars = lit ? 2'd1 : 2'd3;
    assign sum     = {1'b0, line_column_reg} + {6'b000000, n_chars};
    // Saturate rather than wrap.
    assign col     = sum[7] ? COL_MAX : sum[6:0];
    assign brk     = (col >= break_column_reg);

    always_comb
    begin
        q_data.data    = in_byte;
        q_data.literal = lit;
        q_data.brk     = brk;
        line_column_next = line_column_reg;
        if (q_write)
        begin
            line_column_next = (brk || message_end) ? 7'd0 : col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            break_column_reg <= BREAK_RESET;
            line_column_reg  <= 7'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                break_column_reg <= break_column;
            end
            line_column_reg <= line_column_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/qpe_fifo.sv
`default_nettype none

`include "assert_macros.svh"

module qpe_fifo
    import qpe_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr,
    input  wire job_t wr_data,
    output logic      full,
    input  wire logic rd,
    output logic      valid,
    output job_t      rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign valid   = (cnt_reg != '0);
    assign rd_data = slots[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slots[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    `QPE_ASSERT_SAME(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(DEPTH))
    `QPE_ASSERT_SAME(a_no_overflow, clk, rst_n, wr, !full || rd)
    `QPE_ASSERT_SAME(a_no_underflow, clk, rst_n, rd, valid)

endmodule

`default_nettype wire

>>> rtl/core/qpe_back.sv
`default_nettype none

`include "assert_macros.svh"

module qpe_back
    import qpe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  wire job_t       q_data,
    output logic            q_read,
    output logic [7:0]      out_char,
    output logic            last_of_run,
    output logic            empty,
    input  wire logic       pop
);

    localparam logic [2:0] STEP_HEAD = 3'd0;
    localparam logic [2:0] STEP_HI   = 3'd1;
    localparam logic [2:0] STEP_LO   = 3'd2;
    localparam logic [2:0] STEP_EQ   = 3'd3;
    localparam logic [2:0] STEP_CR   = 3'd4;
    localparam logic [2:0] STEP_LF   = 3'd5;

    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       out_last_reg;
    logic       load;
    logic [7:0] ch;
    logic       last;
    logic [2:0] step_after;

    assign load        = q_valid && (!out_valid_reg || pop);
    assign q_read      = load && last;
    assign empty       = !out_valid_reg;
    assign out_char    = out_char_reg;
    assign last_of_run = out_last_reg;

    always_comb
    begin
        unique case (step_reg)
            STEP_HEAD:
            begin
                ch         = q_data.literal ? q_data.data : CHAR_EQ;
                last       = q_data.literal && !q_data.brk;
                step_after = q_data.literal ? STEP_EQ : STEP_HI;
            end
            STEP_HI:
            begin
                ch         = hex_char(q_data.data[7:4]);
                last       = 1'b0;
                step_after = STEP_LO;
            end
            STEP_LO:
            begin
                ch         = hex_char(q_data.data[3:0]);
                last       = !q_data.brk;
                step_after = STEP_EQ;
            end
            STEP_EQ:
            begin
                ch         = CHAR_EQ;
                last       = 1'b0;
                step_after = STEP_CR;
            end
            STEP_CR:
            begin
                ch         = CHAR_CR;
                last       = 1'b0;
                step_after = STEP_LF;
            end
            STEP_LF:
            begin
                ch         = CHAR_LF;
                last       = 1'b1;
                step_after = STEP_HEAD;
            end
            default:
            begin
                ch         = 8'h00;
                last       = 1'b1;
                step_after = STEP_HEAD;
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (load)
        begin
            step_next = last ? STEP_HEAD : step_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= ch;
            out_last_reg <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_HEAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Mid-job the job must still sit at the queue head.
    `QPE_ASSERT_SAME(a_job_held, clk, rst_n, step_reg != STEP_HEAD, q_valid)
    `QPE_ASSERT_NEXT(a_last_done, clk, rst_n, q_read, step_reg == STEP_HEAD)
    `QPE_ASSERT_SAME(a_step_range, clk, rst_n, 1'b1, step_reg <= STEP_LF)

endmodule

`default_nettype wire

>>> rtl/core/quoted_printable_encoder.sv
// An accepted beat is written into the job queue, then loaded into the output register before
// its first character can be popped. Throughput: input beats are taken every cycle while the
// job queue has room; output runs one character per cycle while pop keeps up, and a byte gives
// 1 to 6 characters (1 literal, 3 escaped, +3 per break). Sustained rate is set by the character
// emitter; the queue absorbs bursts of QUEUE_DEPTH bytes.
// Reset (rst_n low, async): queue and output empty, column 0, break column 73.
`default_nettype none

module quoted_printable_encoder
    import qpe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration: break column, written while idle
    input  wire logic       cfg_write,
    input  wire logic [6:0] break_column,
    // input queue side
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] in_byte,
    input  wire logic       message_end,
    // result queue side
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_char,
    output logic            last_of_run
);

    // Front end: classify each byte, track the line column, decide on the soft break.
    // Everything the next byte needs is known at accept time, so the front never waits
    // on the emitter except through the queue filling up.
    logic q_write;
    job_t q_wdata;
    logic q_full;
    logic q_read;
    logic q_valid;
    job_t q_rdata;

    assign full = q_full;

    qpe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .break_column (break_column),
        .push         (push),
        .in_byte      (in_byte),
        .message_end  (message_end),
        .q_full       (q_full),
        .q_write      (q_write),
        .q_data       (q_wdata)
    );

    // Job queue: holds classified bytes between the front end and the emitter.
    qpe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_write),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd      (q_read),
        .valid   (q_valid),
        .rd_data (q_rdata)
    );

    // Emitter: step through the characters of the head job into the output register;
    // drop the job from the queue as its final character loads.
    qpe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (q_rdata),
        .q_read      (q_read),
        .out_char    (out_char),
        .last_of_run (last_of_run),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

`default_nettype wire
